### rtl/integer_to_radix_digits_assert.svh
// Assertion macros for the RTL files, included by itrd_back.
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ITRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itrd assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define ITRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itrd assertion failed");

`endif

### rtl/itrd_pkg.sv
`default_nettype none
package itrd_pkg;

  // Field widths
  localparam int VALUE_BITS  = 31;
  localparam int RADIX_BITS  = 5;
  localparam int DIGIT_BITS  = 4;
  localparam int SYM_BITS    = 8;
  localparam int WORD_BITS   = 64;
  localparam int MAX_SYMBOLS = 16;

  // Divider: 32-bit dividend, eight restoring steps per cycle
  localparam int DIV_BITS   = 32;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = DIV_BITS / DIV_STEPS;
  localparam int STEP_BITS  = $clog2(DIV_CYCLES);

  // Digit buffer: at most VALUE_BITS digits (radix two)
  localparam int IDX_BITS = $clog2(VALUE_BITS);

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SYM_LOW  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SYM_HIGH = 2'd2;

  // Reset values
  localparam logic [RADIX_BITS-1:0] RADIX_RESET     = 5'd10;
  localparam logic [WORD_BITS-1:0]  SYM_LOW_RESET   = 64'h3736353433323130;
  localparam logic [WORD_BITS-1:0]  SYM_HIGH_RESET  = 64'h6665646362613938;

  // One queued item
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  zero;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } back_state_e;

  // Clamp the radix register into 2..MAX_SYMBOLS
  function automatic logic [RADIX_BITS-1:0] eff_radix(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] res;
    res = r;
    if (r < RADIX_BITS'(2)) begin
      res = RADIX_BITS'(2);
    end else if (r > RADIX_BITS'(MAX_SYMBOLS)) begin
      res = RADIX_BITS'(MAX_SYMBOLS);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/itrd_front.sv
`default_nettype none
module itrd_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [itrd_pkg::VALUE_BITS-1:0] value_i,
  output logic                              item_valid_o,
  input  wire logic                         item_ready_i,
  output itrd_pkg::item_t                   item_o
);
  import itrd_pkg::*;

  logic  vld_q;
  item_t item_q;

  // Single input register; takes a new transfer whenever it drains
  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Classify: zero needs no division
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.value <= value_i;
      item_q.zero  <= (value_i == '0);
    end
  end

endmodule
`default_nettype wire

### rtl/itrd_queue.sv
`default_nettype none
module itrd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_valid_i,
  output logic                 wr_ready_o,
  input  wire itrd_pkg::item_t wr_item_i,
  output logic                 rd_valid_o,
  input  wire logic            rd_ready_i,
  output itrd_pkg::item_t      rd_item_o
);
  import itrd_pkg::*;

  // Two-entry FIFO between front and back
  item_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule
`default_nettype wire

### rtl/itrd_back.sv
`default_nettype none
`include "integer_to_radix_digits_assert.svh"
module itrd_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [itrd_pkg::RADIX_BITS-1:0]   radix_i,
  input  wire logic [2*itrd_pkg::WORD_BITS-1:0]  sym_tbl_i,
  input  wire logic                              item_valid_i,
  output logic                                   item_ready_o,
  input  wire itrd_pkg::item_t                   item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [itrd_pkg::SYM_BITS-1:0]          symbol_o,
  output logic                                   last_digit_o
);
  import itrd_pkg::*;

  back_state_e             state_q, state_d;
  logic [DIV_BITS-1:0]     num_q, num_d;
  logic [RADIX_BITS-1:0]   rem_q, rem_d;
  logic [STEP_BITS-1:0]    step_q, step_d;
  logic [IDX_BITS-1:0]     cnt_q, cnt_d;
  logic [IDX_BITS-1:0]     idx_q, idx_d;
  logic [DIGIT_BITS-1:0]   dig_q [VALUE_BITS];
  logic                    out_vld_q, out_vld_d;
  logic [SYM_BITS-1:0]     sym_q;
  logic                    last_q;

  logic [RADIX_BITS-1:0]   radix;
  logic [DIV_BITS-1:0]     n_step;
  logic [RADIX_BITS-1:0]   r_step;
  logic                    take;
  logic                    load;
  logic                    dig_we;
  logic [IDX_BITS-1:0]     dig_wa;
  logic [DIGIT_BITS-1:0]   dig_wd;

  assign radix        = eff_radix(radix_i);
  assign item_ready_o = (state_q == ST_IDLE);
  assign take         = item_valid_i && item_ready_o;
  assign load         = (state_q == ST_EMIT) && (!out_vld_q || out_ready_i);

  assign out_valid_o  = out_vld_q;
  assign symbol_o     = sym_q;
  assign last_digit_o = last_q;

  // Eight restoring division steps on the {rem, num} shift pair
  always_comb begin
    n_step = num_q;
    r_step = rem_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r_step = {r_step[RADIX_BITS-2:0], n_step[DIV_BITS-1]};
      n_step = {n_step[DIV_BITS-2:0], 1'b0};
      if (r_step >= radix) begin
        r_step    = r_step - radix;
        n_step[0] = 1'b1;
      end
    end
  end

  // Next state: divide out digits LSB first, then emit from the top down
  always_comb begin
    state_d   = state_q;
    num_d     = num_q;
    rem_d     = rem_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    dig_we    = 1'b0;
    dig_wa    = cnt_q;
    dig_wd    = r_step[DIGIT_BITS-1:0];
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          num_d  = {{(DIV_BITS-VALUE_BITS){1'b0}}, item_i.value};
          rem_d  = '0;
          step_d = '0;
          cnt_d  = '0;
          if (item_i.zero) begin
            dig_we  = 1'b1;
            dig_wa  = '0;
            dig_wd  = '0;
            idx_d   = '0;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        num_d  = n_step;
        rem_d  = r_step;
        step_d = step_q + STEP_BITS'(1);
        if (step_q == STEP_BITS'(DIV_CYCLES - 1)) begin
          dig_we = 1'b1;
          rem_d  = '0;
          if (n_step == '0) begin
            idx_d   = cnt_q;
            state_d = ST_EMIT;
          end else begin
            cnt_d = cnt_q + IDX_BITS'(1);
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_vld_d = 1'b1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - IDX_BITS'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      num_q     <= '0;
      rem_q     <= '0;
      step_q    <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      num_q     <= num_d;
      rem_q     <= rem_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Digit buffer and symbol lookup
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      dig_q[dig_wa] <= dig_wd;
    end
    if (load) begin
      sym_q  <= sym_tbl_i[{dig_q[idx_q], 3'b000} +: SYM_BITS];
      last_q <= (idx_q == '0);
    end
  end

  // Checks
  `ITRD_ASSERT_NOW(a_rem_below_radix, state_q == ST_DIV, rem_q < radix)
  `ITRD_ASSERT_NOW(a_cnt_in_range, state_q == ST_DIV, cnt_q <= IDX_BITS'(VALUE_BITS - 1))
  `ITRD_ASSERT_NEXT(a_take_leaves_idle, take, state_q != ST_IDLE)
  `ITRD_ASSERT_NEXT(a_last_ends_run, load && (idx_q == '0), (state_q == ST_IDLE) && last_q)

endmodule
`default_nettype wire

### rtl/integer_to_radix_digits.sv
// Flow: input register, queue and back end; the back end divides out each digit
// with the divider (8 quotient bits per cycle), then sends the digits out one at a time.
// The back end takes one item at a time and only when idle; the input register
// and queue can hold further values meanwhile.
// Reset (rst_ni low, asynchronous): queue and channels empty, radix 10,
// symbols "0123456789abcdef".
`default_nettype none
module integer_to_radix_digits (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [itrd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [itrd_pkg::WORD_BITS-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [itrd_pkg::VALUE_BITS-1:0]     value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [itrd_pkg::SYM_BITS-1:0]            symbol_o,
  output logic                                     last_digit_o
);
  import itrd_pkg::*;

  logic [RADIX_BITS-1:0] radix_q;
  logic [WORD_BITS-1:0]  sym_low_q;
  logic [WORD_BITS-1:0]  sym_high_q;

  logic  f_valid, f_ready;
  item_t f_item;
  logic  b_valid, b_ready;
  item_t b_item;

  // Configuration registers; writes always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_RESET;
      sym_low_q  <= SYM_LOW_RESET;
      sym_high_q <= SYM_HIGH_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RADIX:    radix_q    <= cfg_data_i[RADIX_BITS-1:0];
        CFG_SYM_LOW:  sym_low_q  <= cfg_data_i;
        CFG_SYM_HIGH: sym_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  itrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  itrd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_item_i  (f_item),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_item_o  (b_item)
  );

  itrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_i      (radix_q),
    .sym_tbl_i    ({sym_high_q, sym_low_q}),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .symbol_o     (symbol_o),
    .last_digit_o (last_digit_o)
  );

endmodule
`default_nettype wire

### dv/integer_to_radix_digits_tb.sv
`default_nettype none
module integer_to_radix_digits_tb;
  import itrd_pkg::*;

  // Index past the end of the register list; writes to it must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 18;

  typedef struct {
    logic [SYM_BITS-1:0] symbol;
    logic                last;
  } digit_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [WORD_BITS-1:0]    cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [VALUE_BITS-1:0]   value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b1;
  logic [SYM_BITS-1:0]     symbol_o;
  logic                    last_digit_o;

  // Shadow copy of the configuration registers
  logic [RADIX_BITS-1:0] radix_q = RADIX_RESET;
  logic [WORD_BITS-1:0]  sym_lo_q = SYM_LOW_RESET;
  logic [WORD_BITS-1:0]  sym_hi_q = SYM_HIGH_RESET;

  digit_t pending_digits[$];
  bit     stalls_on = 1'b1;
  int     stall_odds = 8;
  int     hold_cnt = 0;
  int     n_errors = 0;
  int     items_sent = 0;
  int     digits_seen = 0;
  int     cfg_writes = 0;

  integer_to_radix_digits u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .symbol_o     (symbol_o),
    .last_digit_o (last_digit_o)
  );

  always #5 clk_i = ~clk_i;

  // Expected digit symbols for one value, most significant first
  function automatic void expand_digits(input logic [VALUE_BITS-1:0] v);
    logic [DIGIT_BITS-1:0] digs[VALUE_BITS];
    logic [31:0] rem;
    logic [31:0] base;
    int n;
    int k;
    digit_t e;
    base = 32'(radix_q);
    if (base < 2) base = 2;
    if (base > MAX_SYMBOLS) base = MAX_SYMBOLS;
    rem = 32'(v);
    n = 0;
    do begin
      digs[n] = DIGIT_BITS'(rem % base);
      n++;
      rem = rem / base;
    end while (rem != 0);
    for (k = n - 1; k >= 0; k--) begin
      e.symbol = digs[k][3] ? sym_hi_q[digs[k][2:0]*8 +: 8] : sym_lo_q[digs[k][2:0]*8 +: 8];
      e.last   = (k == 0);
      pending_digits.push_back(e);
    end
  endfunction

  // Receiver: random stall bursts on out_ready_i
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= hold_cnt - 1;
    end else if (stalls_on && $urandom_range(0, stall_odds) == 0) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each output transfer against the oldest expected digit
  always @(posedge clk_i) begin
    digit_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      digits_seen++;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit: symbol %02h last %0b", $time, symbol_o,
                 last_digit_o);
        n_errors++;
      end else begin
        e = pending_digits.pop_front();
        if (symbol_o !== e.symbol) begin
          $display("%0t: symbol mismatch: expected %02h, actual %02h", $time, e.symbol,
                   symbol_o);
          n_errors++;
        end
        if (last_digit_o !== e.last) begin
          $display("%0t: last_digit mismatch: expected %0b, actual %0b", $time, e.last,
                   last_digit_o);
          n_errors++;
        end
      end
    end
  end

  // Register write; valid stays up so back-to-back writes need no re-raise
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [WORD_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
    case (idx)
      CFG_RADIX:    radix_q  = data[RADIX_BITS-1:0];
      CFG_SYM_LOW:  sym_lo_q = data;
      CFG_SYM_HIGH: sym_hi_q = data;
      default: ;
    endcase
  endtask

  // Radix write with random junk above the five used bits
  task automatic set_radix(input logic [RADIX_BITS-1:0] r);
    cfg_write(CFG_RADIX, {$urandom, $urandom} & ~64'h1f | WORD_BITS'(r));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_symbols(input logic [WORD_BITS-1:0] lo, input logic [WORD_BITS-1:0] hi);
    cfg_write(CFG_SYM_LOW, lo);
    cfg_write(CFG_SYM_HIGH, hi);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One input transfer, with an optional idle gap in front
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    expand_digits(v);
  endtask

  // Drop valid, let every expected digit arrive, then cover the back-end tail
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_value(0);
    send_value(9);
    send_value(10);
    send_value(1000000000);
    send_value(999999999);
    send_value(31'h7fffffff);
    settle();
  endtask

  task automatic test_radix_extremes();
    set_radix(2);
    send_value(1);
    send_value(31'h40000000);
    send_value(31'h7fffffff);
    settle();
    set_radix(16);
    send_value(31'h10000000);
    send_value(31'h7fffffff);
    settle();
    // radix below two falls back to binary
    set_radix(0);
    send_value(5);
    settle();
    set_radix(1);
    send_value(6);
    settle();
    // radix above the table clamps to sixteen
    set_radix(17);
    send_value(255);
    settle();
    set_radix(31);
    send_value(256);
    settle();
    set_radix(3);
    send_value(1162261467);
    settle();
  endtask

  task automatic test_symbol_tables();
    set_radix(16);
    set_symbols({64{1'b1}}, '0);
    send_value(31'h01234567);
    send_value(31'h789abcde);
    settle();
    set_symbols({$urandom, $urandom}, {$urandom, $urandom});
    send_value(31'h7fedcba9);
    send_value(0);
    settle();
  endtask

  task automatic test_ignored_index();
    cfg_write(CFG_UNUSED, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    send_value(31'h07654321);
    settle();
    set_radix(RADIX_RESET);
    set_symbols(SYM_LOW_RESET, SYM_HIGH_RESET);
    cfg_write(CFG_UNUSED, '0);
    cfg_valid_i <= 1'b0;
    send_value(12345);
    settle();
  endtask

  task automatic test_random_conversions();
    logic [RADIX_BITS-1:0] r;
    logic [63:0] p;
    logic [31:0] base;
    logic [VALUE_BITS-1:0] v;
    int ph;
    int i;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      // last phase runs without any idling
      stalls_on  = (ph < RAND_PHASES - 1);
      stall_odds = $urandom_range(2, 12);
      case ($urandom_range(0, 3))
        0: r = RADIX_BITS'(2);
        1: r = RADIX_BITS'(16);
        default: r = RADIX_BITS'($urandom);
      endcase
      set_radix(r);
      if ($urandom_range(0, 3) == 0) set_symbols(SYM_LOW_RESET, SYM_HIGH_RESET);
      else set_symbols({$urandom, $urandom}, {$urandom, $urandom});
      base = (r < 2) ? 2 : (r > MAX_SYMBOLS) ? MAX_SYMBOLS : 32'(r);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 3))
          0: v = VALUE_BITS'($urandom);
          1: v = VALUE_BITS'($urandom >> $urandom_range(0, 31));
          2: begin
            // near an exact power of the radix
            p = 1;
            repeat ($urandom_range(0, 30)) if (p * base <= 64'h7fffffff) p = p * base;
            case ($urandom_range(0, 2))
              0: v = VALUE_BITS'(p);
              1: v = VALUE_BITS'(p - 1);
              default: v = (p == 64'h7fffffff) ? VALUE_BITS'(p) : VALUE_BITS'(p + 1);
            endcase
          end
          default: v = VALUE_BITS'($urandom_range(0, 2 * base));
        endcase
        send_value(v);
      end
      settle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_radix_extremes();
    test_symbol_tables();
    test_ignored_index();
    test_random_conversions();
    $display("Converted %0d values into %0d digits over %0d register writes,",
             items_sent, digits_seen, cfg_writes);
    $display("radix 0..31 incl. clamped bases, custom symbol tables, idle and stall bursts.");
    if (n_errors == 0) begin
      $display("PASS integer_to_radix_digits");
    end else begin
      $display("FAIL integer_to_radix_digits");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("FAIL integer_to_radix_digits");
    $finish;
  end

endmodule
`default_nettype wire
